>>> sv/cpt_pkg.sv
// Shared types and constants of the call permission table.
`timescale 1ns / 1ps

package cpt_pkg;

   localparam int EP_W    = 32;
   localparam int PROC_W  = 8;
   localparam int CALL_W  = 6;
   localparam int MASK_W  = 64;
   localparam int SLOT_W  = 7;
   localparam int CSR_IDX_W = 1;

   localparam logic [SLOT_W-1:0] SLOT_NONE = 7'd64;
   localparam logic [SLOT_W-1:0] SLOT_USER = 7'd0;

   localparam logic [EP_W-1:0] SELF_EP_RESET    = 32'd8;
   localparam logic [EP_W-1:0] SERVICE_EP_RESET = 32'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SELF_ENDPOINT    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SERVICE_ENDPOINT = 1'b1;

   typedef enum logic [1:0] {
      FUNC_CHECK = 2'd0,
      FUNC_SET   = 2'd1,
      FUNC_FORK  = 2'd2,
      FUNC_CLEAR = 2'd3
   } cpt_func_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_DENIED  = 2'd1,
      STATUS_NO_SLOT = 2'd2
   } cpt_status_type;

   typedef struct packed {
      logic [1:0]        func;
      logic [PROC_W-1:0] proc_index;
      logic [EP_W-1:0]   caller_endpoint;
      logic [CALL_W-1:0] call_number;
      logic              is_system;
      logic              mask_given;
      logic [MASK_W-1:0] call_mask;
   } cpt_req_type;

   // Partial result handed from the slot stage to the output register.
   typedef struct packed {
      cpt_status_type    status;
      logic              warn_no_slot;
      logic              warn_uninitialized;
      logic [SLOT_W-1:0] slot_now;
      logic              need_mask;
      logic [CALL_W-1:0] call_number;
   } cpt_res_type;

   typedef struct packed {
      logic              wr_en;
      logic [SLOT_W-1:0] addr;
      logic [MASK_W-1:0] wr_data;
   } cpt_mask_acc_type;

endpackage

>>> sv/cpt_req_if.sv
// Request channel interface of the call permission table.
`timescale 1ns / 1ps

interface cpt_req_if
   import cpt_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [1:0]        func;
   logic [PROC_W-1:0] proc_index;
   logic [EP_W-1:0]   caller_endpoint;
   logic [CALL_W-1:0] call_number;
   logic              is_system;
   logic              mask_given;
   logic [MASK_W-1:0] call_mask;

   modport source (
      output valid, func, proc_index, caller_endpoint, call_number,
             is_system, mask_given, call_mask,
      input  ready
   );

   modport sink (
      input  valid, func, proc_index, caller_endpoint, call_number,
             is_system, mask_given, call_mask,
      output ready
   );
endinterface

>>> sv/cpt_rsp_if.sv
// Response channel interface of the call permission table.
`timescale 1ns / 1ps

interface cpt_rsp_if
   import cpt_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic              warn_no_slot;
   logic              warn_uninitialized;
   logic [SLOT_W-1:0] slot_now;

   modport source (
      output valid, status, warn_no_slot, warn_uninitialized, slot_now,
      input  ready
   );

   modport sink (
      input  valid, status, warn_no_slot, warn_uninitialized, slot_now,
      output ready
   );
endinterface

>>> sv/cpt_mask_store.sv
// Call mask memory with per-slot valid bits and a registered read port.
`timescale 1ns / 1ps

module cpt_mask_store
   import cpt_pkg::*;
#(
   parameter int MASK_SLOTS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  cpt_mask_acc_type  acc,
   output logic [MASK_W-1:0] rd_bits
);

   localparam int MIDX_W = $clog2(MASK_SLOTS);

   logic [MASK_W-1:0]     mask_mem [MASK_SLOTS];
   logic [MASK_SLOTS-1:0] mask_vld_ff;
   logic [MASK_W-1:0]     rd_data_ff;
   logic                  rd_vld_ff;
   logic [MIDX_W-1:0]     addr;

   assign addr = acc.addr[MIDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_vld_ff <= '0;
      end else if (advance && acc.wr_en) begin
         mask_vld_ff[addr] <= 1'b1;
      end
   end

   // Every transaction reads the store; one that also writes reads the old word.
   always_ff @(posedge clock) begin
      if (advance) begin
         if (acc.wr_en) begin
            mask_mem[addr] <= acc.wr_data;
         end
         rd_data_ff <= mask_mem[addr];
         rd_vld_ff  <= mask_vld_ff[addr];
      end
   end

   // Slots never written read as an all-zero mask.
   assign rd_bits = rd_vld_ff ? rd_data_ff : '0;

endmodule

>>> sv/cpt_slot_stage.sv
// Slot stage: process slot table, in-use bitmap and per-operation update.
`timescale 1ns / 1ps

module cpt_slot_stage
   import cpt_pkg::*;
#(
   parameter int PROC_SLOTS = 256,
   parameter int MASK_SLOTS = 64,
   parameter int CALL_COUNT = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  logic             advance,
   input  cpt_req_type      req,
   input  logic [EP_W-1:0]  self_endpoint,
   input  logic [EP_W-1:0]  service_endpoint,
   output cpt_res_type      res,
   output cpt_mask_acc_type mask_acc
);

   localparam int PIDX_W = $clog2(PROC_SLOTS);
   localparam int MIDX_W = $clog2(MASK_SLOTS);
   localparam logic [MASK_W-1:0] CALL_BITS =
      (CALL_COUNT >= MASK_W) ? {MASK_W{1'b1}} : ((64'd1 << CALL_COUNT) - 64'd1);

   logic [SLOT_W-1:0]     slot_mem [PROC_SLOTS];
   logic [PROC_SLOTS-1:0] slot_vld_ff;
   logic [MASK_SLOTS-1:0] in_use_ff;
   logic [MASK_SLOTS-1:0] in_use_in;
   cpt_req_type           item_ff;
   logic [SLOT_W-1:0]     rd_slot_ff;
   logic                  fwd_hit_ff;
   logic [SLOT_W-1:0]     fwd_slot_ff;

   logic [PIDX_W-1:0]     item_idx;
   logic [PIDX_W-1:0]     req_idx;
   logic                  in_range;
   logic [SLOT_W-1:0]     slot_cur;
   logic                  slot_sys;
   logic [MIDX_W-1:0]     slot_idx;
   logic [MASK_SLOTS-1:0] freed;
   logic                  free_found;
   logic [MIDX_W-1:0]     free_idx;
   logic [MIDX_W-1:0]     set_idx;
   logic                  set_found;
   logic [SLOT_W-1:0]     new_slot;
   logic                  slot_wr;

   assign item_idx = PIDX_W'(item_ff.proc_index);
   assign req_idx  = PIDX_W'(req.proc_index);
   assign in_range = 32'(item_ff.proc_index) < 32'(PROC_SLOTS);

   // The entry written at the edge that read this transaction's slot is
   // still stale in the read register, so it is taken from the bypass.
   assign slot_cur = fwd_hit_ff ? fwd_slot_ff :
                     (slot_vld_ff[item_idx] ? rd_slot_ff : SLOT_NONE);
   assign slot_sys = (slot_cur != SLOT_NONE) && (slot_cur != SLOT_USER);
   assign slot_idx = slot_cur[MIDX_W-1:0];

   always_comb begin
      freed = in_use_ff;
      if (slot_sys) begin
         freed[slot_idx] = 1'b0;
      end
   end

   // Lowest free system slot.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = MASK_SLOTS - 1; i >= 1; i--) begin
         if (!freed[i]) begin
            free_found = 1'b1;
            free_idx   = MIDX_W'(i);
         end
      end
   end

   assign set_idx   = item_ff.is_system ? free_idx : '0;
   assign set_found = !item_ff.is_system || free_found;

   always_comb begin
      res.status             = STATUS_OK;
      res.warn_no_slot       = 1'b0;
      res.warn_uninitialized = 1'b0;
      res.slot_now           = SLOT_NONE;
      res.need_mask          = 1'b0;
      res.call_number        = item_ff.call_number;
      new_slot               = slot_cur;
      slot_wr                = 1'b0;
      in_use_in              = in_use_ff;
      mask_acc.wr_en         = 1'b0;
      mask_acc.addr          = slot_cur;
      mask_acc.wr_data       = item_ff.call_mask & CALL_BITS;
      if (in_range) begin
         unique case (cpt_func_type'(item_ff.func))
            FUNC_CHECK: begin
               if (item_ff.caller_endpoint == self_endpoint) begin
                  res.status = STATUS_OK;
               end else if (slot_cur == SLOT_NONE) begin
                  res.warn_no_slot = item_ff.caller_endpoint != service_endpoint;
               end else if (32'(item_ff.call_number) >= 32'(CALL_COUNT)) begin
                  res.status = STATUS_DENIED;
               end else begin
                  res.need_mask = 1'b1;
               end
            end
            FUNC_SET: begin
               slot_wr   = 1'b1;
               in_use_in = freed;
               if (set_found) begin
                  res.warn_uninitialized = !freed[set_idx] && !item_ff.mask_given;
                  in_use_in[set_idx]     = 1'b1;
                  new_slot               = SLOT_W'(set_idx);
                  mask_acc.wr_en         = item_ff.mask_given;
                  mask_acc.addr          = SLOT_W'(set_idx);
               end else begin
                  res.status = STATUS_NO_SLOT;
                  new_slot   = SLOT_NONE;
               end
            end
            FUNC_FORK: begin
               slot_wr = 1'b1;
               if (slot_cur != SLOT_USER) begin
                  new_slot = SLOT_NONE;
               end
            end
            FUNC_CLEAR: begin
               slot_wr   = 1'b1;
               in_use_in = freed;
               new_slot  = SLOT_NONE;
            end
            default: begin
               slot_wr = 1'b0;
            end
         endcase
         res.slot_now = new_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_vld_ff <= '0;
         in_use_ff   <= '0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         if (advance) begin
            in_use_ff <= in_use_in;
            if (slot_wr) begin
               slot_vld_ff[item_idx] <= 1'b1;
            end
         end
         if (load) begin
            fwd_hit_ff <= advance && slot_wr && (item_idx == req_idx);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && slot_wr) begin
         slot_mem[item_idx] <= new_slot;
      end
      if (load) begin
         item_ff     <= req;
         rd_slot_ff  <= slot_mem[req_idx];
         fwd_slot_ff <= new_slot;
      end
   end

endmodule

>>> sv/call_permission_table_core.sv
// Top level of the call permission table: channels, registers, output stage.
`timescale 1ns / 1ps
//
// Call permission table. Each request transaction on req_chan carries an
// operation (check, set mask, fork or clear) for one process entry and
// yields exactly one response transaction on rsp_chan, in request order.
// Both channels use a valid/ready handshake; a transaction moves at a rising
// edge with valid and ready high. The csr_ port writes the owning server's
// endpoint (index 0) and the service endpoint (index 1); write it only while
// no transaction is in flight.
// A request is held in the slot stage register, and its result then in the
// output register, which drives the response; a receiver stall delays it.
// Throughput: one transaction per cycle while the receiver takes responses.
// A request is registered and reads the slot table; when it advances, the
// slot stage updates the table and bitmap, reads the mask memory and may
// write it; the output register then selects the mask bit. Back-to-back
// requests to the same process bypass the slot memory's read register.
// Reset clears every table at once through valid bits; the block accepts
// requests in the first cycle after reset. When the receiver stalls, the
// response is held and one further request is still accepted before
// req_chan.ready falls.
//
module call_permission_table_core
   import cpt_pkg::*;
#(
   parameter int PROC_SLOTS = 256,
   parameter int MASK_SLOTS = 64,
   parameter int CALL_COUNT = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   cpt_req_if.sink              req_chan,
   cpt_rsp_if.source            rsp_chan,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [EP_W-1:0]      csr_wr_data
);

   logic             s1_vld_ff;
   logic             s2_vld_ff;
   cpt_res_type      res_ff;
   logic [EP_W-1:0]  self_ep_ff;
   logic [EP_W-1:0]  service_ep_ff;
   logic             s2_free;
   logic             s1_advance;
   logic             req_fire;
   cpt_req_type      req;
   cpt_res_type      s1_res;
   cpt_mask_acc_type mask_acc;
   logic [MASK_W-1:0] mask_bits;
   cpt_status_type   rsp_status;

   assign s2_free        = !s2_vld_ff || rsp_chan.ready;
   assign s1_advance     = s1_vld_ff && s2_free;
   assign req_chan.ready = !s1_vld_ff || s2_free;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign req.func            = req_chan.func;
   assign req.proc_index      = req_chan.proc_index;
   assign req.caller_endpoint = req_chan.caller_endpoint;
   assign req.call_number     = req_chan.call_number;
   assign req.is_system       = req_chan.is_system;
   assign req.mask_given      = req_chan.mask_given;
   assign req.call_mask       = req_chan.call_mask;

   always_ff @(posedge clock) begin
      if (reset) begin
         self_ep_ff    <= SELF_EP_RESET;
         service_ep_ff <= SERVICE_EP_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SELF_ENDPOINT:    self_ep_ff    <= csr_wr_data;
            CSR_SERVICE_ENDPOINT: service_ep_ff <= csr_wr_data;
            default:              self_ep_ff    <= self_ep_ff;
         endcase
      end
   end

   cpt_slot_stage #(
      .PROC_SLOTS (PROC_SLOTS),
      .MASK_SLOTS (MASK_SLOTS),
      .CALL_COUNT (CALL_COUNT)
   ) u_slot_stage (
      .clock            (clock),
      .reset            (reset),
      .load             (req_fire),
      .advance          (s1_advance),
      .req              (req),
      .self_endpoint    (self_ep_ff),
      .service_endpoint (service_ep_ff),
      .res              (s1_res),
      .mask_acc         (mask_acc)
   );

   cpt_mask_store #(
      .MASK_SLOTS (MASK_SLOTS)
   ) u_mask_store (
      .clock   (clock),
      .reset   (reset),
      .advance (s1_advance),
      .acc     (mask_acc),
      .rd_bits (mask_bits)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            s1_vld_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_vld_ff <= 1'b0;
         end
         if (s1_advance) begin
            s2_vld_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            s2_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         res_ff <= s1_res;
      end
   end

   // A check that reached the mask is denied unless the call's bit is set.
   assign rsp_status = (res_ff.need_mask && !mask_bits[res_ff.call_number]) ?
                       STATUS_DENIED : res_ff.status;

   assign rsp_chan.valid              = s2_vld_ff;
   assign rsp_chan.status             = rsp_status;
   assign rsp_chan.warn_no_slot       = res_ff.warn_no_slot;
   assign rsp_chan.warn_uninitialized = res_ff.warn_uninitialized;
   assign rsp_chan.slot_now           = res_ff.slot_now;

   a_no_slot_leaves_none: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.status == STATUS_NO_SLOT) |->
      rsp_chan.slot_now == SLOT_NONE)
      else $error("no free system slot reported but process holds a slot");

   a_warn_no_slot_only_without_slot: assert property (@(posedge clock)
      disable iff (reset)
      rsp_chan.valid && rsp_chan.warn_no_slot |->
      (rsp_chan.slot_now == SLOT_NONE) && (rsp_chan.status == STATUS_OK))
      else $error("no-slot warning on a process that has a slot");

   a_warn_uninit_has_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.warn_uninitialized |->
      (rsp_chan.slot_now != SLOT_NONE) && (rsp_chan.status == STATUS_OK))
      else $error("uninitialised warning without a slot being taken");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_vld_ff)
      else $error("accepted transaction lost from the slot stage");

   a_full_pipe_blocks: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && s2_vld_ff && !rsp_chan.ready |-> !req_chan.ready)
      else $error("request accepted while both stages are full and stalled");

endmodule

>>> tb/tb_call_permission_table_core.sv
// Self-checking testbench for the call permission table core.
`timescale 1ns / 1ps

module tb_call_permission_table_core
   import cpt_pkg::*;
();

   localparam int PROC_COUNT = 256;
   localparam int MASK_COUNT = 64;

   typedef struct packed {
      cpt_status_type    status;
      logic              warn_no_slot;
      logic              warn_uninitialized;
      logic [SLOT_W-1:0] slot_now;
   } perm_result_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [EP_W-1:0]      csr_wr_data;

   cpt_req_if req_bus ();
   cpt_rsp_if rsp_bus ();

   call_permission_table_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Shadow copy of the table state and the two endpoint registers.
   logic [SLOT_W-1:0] slot_of_proc [PROC_COUNT];
   logic [MASK_W-1:0] call_mask_mem [MASK_COUNT];
   logic [MASK_COUNT-1:0] slot_busy;
   logic [EP_W-1:0]   self_ep_model;
   logic [EP_W-1:0]   service_ep_model;

   cpt_req_type     pending_requests [$];
   perm_result_type expected_results [$];
   cpt_req_type     driven_req;

   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   int unsigned mismatch_count;
   int unsigned response_count;
   int unsigned func_count [4];
   int unsigned denied_count;
   int unsigned no_free_count;
   int unsigned warn_ns_count;
   int unsigned warn_un_count;

   perm_result_type got_result;
   perm_result_type want_result;
   perm_result_type new_result;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d responses still outstanding", expected_results.size());
      $display("status: fail");
      $finish;
   end

   task automatic release_slot(input logic [PROC_W-1:0] proc);
      logic [SLOT_W-1:0] held;
      held = slot_of_proc[proc];
      if (held != SLOT_NONE) begin
         if (held != SLOT_USER)
            slot_busy[held[5:0]] = 1'b0;
         slot_of_proc[proc] = SLOT_NONE;
      end
   endtask

   // Applies one request to the shadow state and returns the response it should give.
   task automatic apply_request(input cpt_req_type rq, output perm_result_type res);
      logic [SLOT_W-1:0] held;
      logic [SLOT_W-1:0] pick;
      logic              found;
      res.status             = STATUS_OK;
      res.warn_no_slot       = 1'b0;
      res.warn_uninitialized = 1'b0;
      held = slot_of_proc[rq.proc_index];
      case (cpt_func_type'(rq.func))
         FUNC_CHECK: begin
            if (rq.caller_endpoint == self_ep_model) begin
               res.status = STATUS_OK;
            end else if (held == SLOT_NONE) begin
               res.warn_no_slot = (rq.caller_endpoint != service_ep_model);
            end else if (!call_mask_mem[held[5:0]][rq.call_number]) begin
               res.status = STATUS_DENIED;
            end
         end
         FUNC_SET: begin
            release_slot(rq.proc_index);
            pick  = SLOT_USER;
            found = 1'b1;
            if (rq.is_system) begin
               found = 1'b0;
               for (int i = 1; i < MASK_COUNT; i++) begin
                  if (!found && !slot_busy[i]) begin
                     pick  = SLOT_W'(i);
                     found = 1'b1;
                  end
               end
            end
            if (!found) begin
               res.status = STATUS_NO_SLOT;
            end else begin
               res.warn_uninitialized = !slot_busy[pick[5:0]] && !rq.mask_given;
               slot_busy[pick[5:0]] = 1'b1;
               slot_of_proc[rq.proc_index] = pick;
               if (rq.mask_given)
                  call_mask_mem[pick[5:0]] = rq.call_mask;
            end
         end
         FUNC_FORK: begin
            // The slot is dropped but stays marked in use.
            if (held != SLOT_USER)
               slot_of_proc[rq.proc_index] = SLOT_NONE;
         end
         default: begin
            release_slot(rq.proc_index);
         end
      endcase
      res.slot_now = slot_of_proc[rq.proc_index];
   endtask

   task automatic add_request(input cpt_func_type func, input int unsigned proc,
                              input logic [EP_W-1:0] caller, input int unsigned call,
                              input logic sys, input logic given,
                              input logic [MASK_W-1:0] mask);
      cpt_req_type rq;
      rq.func            = func;
      rq.proc_index      = PROC_W'(proc);
      rq.caller_endpoint = caller;
      rq.call_number     = CALL_W'(call);
      rq.is_system       = sys;
      rq.mask_given      = given;
      rq.call_mask       = mask;
      pending_requests.push_back(rq);
   endtask

   function automatic cpt_req_type random_request();
      cpt_req_type rq;
      int unsigned roll;
      roll = $urandom_range(99);
      rq.func = (roll < 40) ? FUNC_CHECK : (roll < 75) ? FUNC_SET :
                (roll < 85) ? FUNC_FORK : FUNC_CLEAR;
      // Most traffic lands on two small groups of processes so that state builds up.
      roll = $urandom_range(99);
      if (roll < 60)
         rq.proc_index = PROC_W'($urandom_range(15));
      else if (roll < 85)
         rq.proc_index = PROC_W'($urandom_range(199, 128));
      else
         rq.proc_index = PROC_W'($urandom);
      roll = $urandom_range(99);
      if (roll < 20)
         rq.caller_endpoint = self_ep_model;
      else if (roll < 35)
         rq.caller_endpoint = service_ep_model;
      else if (roll < 50) begin
         case ($urandom_range(3))
            0:       rq.caller_endpoint = 32'h8000_0000;
            1:       rq.caller_endpoint = 32'h7FFF_FFFF;
            2:       rq.caller_endpoint = 32'h0000_0000;
            default: rq.caller_endpoint = 32'hFFFF_FFFF;
         endcase
      end else
         rq.caller_endpoint = $urandom;
      rq.call_number = CALL_W'($urandom);
      rq.is_system   = 1'($urandom_range(1));
      rq.mask_given  = ($urandom_range(99) < 70);
      rq.call_mask   = {$urandom, $urandom};
      return rq;
   endfunction

   task automatic write_endpoint(input logic [CSR_IDX_W-1:0] idx, input logic [EP_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      if (idx == CSR_SELF_ENDPOINT)
         self_ep_model = value;
      else
         service_ep_model = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_for_drain();
      while (pending_requests.size() != 0 || req_bus.valid || expected_results.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Request driver: predicts on every accepted transaction, then offers the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            apply_request(driven_req, new_result);
            expected_results.push_back(new_result);
            func_count[driven_req.func]++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               driven_req = pending_requests.pop_front();
               req_bus.func            <= driven_req.func;
               req_bus.proc_index      <= driven_req.proc_index;
               req_bus.caller_endpoint <= driven_req.caller_endpoint;
               req_bus.call_number     <= driven_req.call_number;
               req_bus.is_system       <= driven_req.is_system;
               req_bus.mask_given      <= driven_req.mask_given;
               req_bus.call_mask       <= driven_req.call_mask;
               req_bus.valid           <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Response monitor.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got_result.status             = cpt_status_type'(rsp_bus.status);
         got_result.warn_no_slot       = rsp_bus.warn_no_slot;
         got_result.warn_uninitialized = rsp_bus.warn_uninitialized;
         got_result.slot_now           = rsp_bus.slot_now;
         response_count++;
         if (got_result.status == STATUS_DENIED)  denied_count++;
         if (got_result.status == STATUS_NO_SLOT) no_free_count++;
         if (got_result.warn_no_slot)             warn_ns_count++;
         if (got_result.warn_uninitialized)       warn_un_count++;
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("response %0d arrived with nothing expected: status %0d slot %0d",
                        response_count, got_result.status, got_result.slot_now);
         end else begin
            want_result = expected_results.pop_front();
            if (got_result.status !== want_result.status ||
                got_result.warn_no_slot !== want_result.warn_no_slot ||
                got_result.warn_uninitialized !== want_result.warn_uninitialized ||
                got_result.slot_now !== want_result.slot_now) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("response %0d expected: status %0d no_slot %0b uninit %0b slot %0d",
                           response_count, want_result.status, want_result.warn_no_slot,
                           want_result.warn_uninitialized, want_result.slot_now);
                  $display("response %0d got:      status %0d no_slot %0b uninit %0b slot %0d",
                           response_count, got_result.status, got_result.warn_no_slot,
                           got_result.warn_uninitialized, got_result.slot_now);
               end
            end
         end
      end
   end

   initial begin
      reset                   = 1'b1;
      csr_wr_en               = 1'b0;
      csr_index               = CSR_SELF_ENDPOINT;
      csr_wr_data             = '0;
      req_bus.valid           = 1'b0;
      req_bus.func            = FUNC_CHECK;
      req_bus.proc_index      = '0;
      req_bus.caller_endpoint = '0;
      req_bus.call_number     = '0;
      req_bus.is_system       = 1'b0;
      req_bus.mask_given      = 1'b0;
      req_bus.call_mask       = '0;
      rsp_bus.ready           = 1'b0;
      send_idle_pct           = 11;
      recv_idle_pct           = 58;
      mismatch_count          = 0;
      response_count          = 0;
      denied_count            = 0;
      no_free_count           = 0;
      warn_ns_count           = 0;
      warn_un_count           = 0;
      for (int i = 0; i < 4; i++)
         func_count[i] = 0;
      for (int i = 0; i < PROC_COUNT; i++)
         slot_of_proc[i] = SLOT_NONE;
      for (int i = 0; i < MASK_COUNT; i++)
         call_mask_mem[i] = '0;
      slot_busy        = '0;
      self_ep_model    = SELF_EP_RESET;
      service_ep_model = SERVICE_EP_RESET;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, run with the endpoint registers at their reset values.
      add_request(FUNC_CHECK, 0, 32'd8, 0, 1'b0, 1'b0, '0);
      add_request(FUNC_CHECK, 0, 32'd2, 0, 1'b0, 1'b0, '0);
      add_request(FUNC_CHECK, 0, 32'h8000_0000, 63, 1'b0, 1'b0, '0);
      add_request(FUNC_SET, 0, 32'd5, 0, 1'b0, 1'b0, '0);
      add_request(FUNC_CHECK, 0, 32'd5, 0, 1'b0, 1'b0, '0);
      add_request(FUNC_SET, 1, 32'd5, 0, 1'b0, 1'b1, '1);
      add_request(FUNC_CHECK, 0, 32'd5, 63, 1'b0, 1'b0, '0);
      add_request(FUNC_SET, 255, 32'd7, 0, 1'b1, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA);
      add_request(FUNC_CHECK, 255, 32'd7, 1, 1'b0, 1'b0, '0);
      add_request(FUNC_CHECK, 255, 32'd7, 0, 1'b0, 1'b0, '0);
      add_request(FUNC_SET, 254, 32'd7, 0, 1'b1, 1'b0, '1);
      add_request(FUNC_CHECK, 254, 32'h7FFF_FFFF, 10, 1'b0, 1'b0, '0);
      add_request(FUNC_SET, 255, 32'd9, 0, 1'b1, 1'b1, 64'h5555_5555_5555_5555);
      add_request(FUNC_CHECK, 255, 32'd9, 0, 1'b0, 1'b0, '0);
      add_request(FUNC_FORK, 255, 32'd9, 0, 1'b0, 1'b0, '0);
      add_request(FUNC_CHECK, 255, 32'd9, 0, 1'b0, 1'b0, '0);
      add_request(FUNC_FORK, 0, 32'd9, 0, 1'b1, 1'b1, '1);
      add_request(FUNC_CLEAR, 254, 32'd9, 0, 1'b1, 1'b1, '1);
      add_request(FUNC_SET, 253, 32'd9, 0, 1'b1, 1'b0, '0);
      add_request(FUNC_SET, 252, 32'd9, 0, 1'b1, 1'b1, '0);
      add_request(FUNC_CLEAR, 0, 32'd9, 0, 1'b0, 1'b0, '0);
      add_request(FUNC_FORK, 100, 32'd9, 0, 1'b0, 1'b0, '0);
      add_request(FUNC_CLEAR, 100, 32'd9, 0, 1'b0, 1'b0, '0);
      add_request(FUNC_SET, 0, 32'd9, 0, 1'b0, 1'b1, 64'h8000_0000_0000_0001);
      add_request(FUNC_CHECK, 1, 32'd5, 63, 1'b0, 1'b0, '0);
      wait_for_drain();

      for (int phase = 1; phase <= 6; phase++) begin
         if (phase == 3) begin
            send_idle_pct = 58;
            recv_idle_pct = 11;
         end else if (phase == 5) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case (phase)
            1: begin
               write_endpoint(CSR_SELF_ENDPOINT, 32'h7FFF_FFFF);
               write_endpoint(CSR_SERVICE_ENDPOINT, 32'h8000_0000);
            end
            2: begin
               write_endpoint(CSR_SELF_ENDPOINT, 32'h8000_0000);
               write_endpoint(CSR_SERVICE_ENDPOINT, 32'h7FFF_FFFF);
            end
            3: begin
               write_endpoint(CSR_SELF_ENDPOINT, 32'h0000_0000);
               write_endpoint(CSR_SERVICE_ENDPOINT, 32'h0000_0000);
            end
            4: begin
               write_endpoint(CSR_SELF_ENDPOINT, 32'hFFFF_FFFF);
               write_endpoint(CSR_SERVICE_ENDPOINT, 32'h0000_0001);
            end
            5: begin
               write_endpoint(CSR_SELF_ENDPOINT, $urandom);
               write_endpoint(CSR_SERVICE_ENDPOINT, $urandom);
            end
            default: begin
               write_endpoint(CSR_SELF_ENDPOINT, SELF_EP_RESET);
               write_endpoint(CSR_SERVICE_ENDPOINT, SERVICE_EP_RESET);
            end
         endcase
         @(negedge clock);
         // Claim every system slot and then some, so that allocation runs dry.
         if (phase == 1) begin
            for (int p = 128; p < 194; p++)
               add_request(FUNC_SET, p, $urandom, $urandom_range(63), 1'b1,
                           1'($urandom_range(1)), {$urandom, $urandom});
         end
         repeat (165) pending_requests.push_back(random_request());
         wait_for_drain();
      end

      repeat (8) @(posedge clock);
      $display("requests: %0d check, %0d set, %0d fork, %0d clear over six endpoint settings",
               func_count[FUNC_CHECK], func_count[FUNC_SET], func_count[FUNC_FORK],
               func_count[FUNC_CLEAR]);
      $display("responses: %0d denied, %0d no free slot, %0d no-slot, %0d uninitialised warnings",
               denied_count, no_free_count, warn_ns_count, warn_un_count);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatch_count,
                  expected_results.size());
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> call_permission_table_core.f
sv/cpt_pkg.sv
sv/cpt_req_if.sv
sv/cpt_rsp_if.sv
sv/cpt_mask_store.sv
sv/cpt_slot_stage.sv
sv/call_permission_table_core.sv
tb/tb_call_permission_table_core.sv
